### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the box search block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### sv/prbs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Box search package
// Types and constants shared by the controller and the datapath.
// ---------------------------------------------------------------------------
package prbs_pkg;
  localparam int CordicSteps = 16;
  localparam int CordicGain = 39797;
  localparam int UnitQ16 = 65536;
  localparam logic [0:0] OpWrite = 1'b0;
  localparam logic [0:0] OpQuery = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_STORE, ST_SCAN, ST_DRAIN, ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture the item
    logic cordic;    // one CORDIC step
    logic store;     // write the tables
    logic issue;     // read one box entry
    logic finish;    // present the result
  } cmd_t;

  typedef struct packed {
    logic cordic_last;
    logic issue_last;
    logic found;
    logic pipe_empty;
    logic is_query;
    logic no_scan;
  } status_t;

  function automatic logic [23:0] arc_step(input logic [3:0] i);
    logic [23:0] r;
    unique case (i)
      4'd0: r = 24'd2097152;  4'd1: r = 24'd1238021;
      4'd2: r = 24'd654136;   4'd3: r = 24'd332050;
      4'd4: r = 24'd166669;   4'd5: r = 24'd83416;
      4'd6: r = 24'd41718;    4'd7: r = 24'd20860;
      4'd8: r = 24'd10430;    4'd9: r = 24'd5215;
      4'd10: r = 24'd2608;    4'd11: r = 24'd1304;
      4'd12: r = 24'd652;     4'd13: r = 24'd326;
      4'd14: r = 24'd163;     default: r = 24'd81;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

### sv/points_in_rotated_box_search.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Rotated box search: writes and point queries over per-batch box tables.
// A write runs the 16 CORDIC steps and then one table store, and the block
// stays busy until both are through, so it takes no new item meanwhile.
// A query scans box_count entries (capped at 256), stopping early on a hit:
// one box read per cycle and a four-stage compare pipeline. The next transfer
// can be taken on the clock edge that ends the result strobe. The receiver
// cannot stall.
// Reset clears the controller and box_count; the tables are undefined until written.
// ---------------------------------------------------------------------------
module points_in_rotated_box_search #(
  parameter int MAX_BOXES = 256,
  parameter int MAX_BATCHES = 4,
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cfg_we,
  input  wire logic [8:0]                    cfg_data,
  input  wire logic                          opcode,
  input  wire logic [1:0]                    batch_sel,
  input  wire logic [7:0]                    box_slot,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y,
  input  wire logic signed [COORD_WIDTH-1:0] coord_z,
  input  wire logic [COORD_WIDTH-2:0]        size_x,
  input  wire logic [COORD_WIDTH-2:0]        size_y,
  input  wire logic [COORD_WIDTH-2:0]        size_z,
  input  wire logic [15:0]                   yaw,
  output logic                               done,
  output logic                               hit,
  output logic [7:0]                         box_index
);
  import prbs_pkg::*;

  // The user must write the box count register only while the block is idle; the block itself does not enforce it.
  logic [8:0] box_count;
  always_ff @(posedge clk) begin
    if (rst) box_count <= '0;
    else if (cfg_we) box_count <= cfg_data;
  end

  cmd_t cmd;
  status_t stat;

  // The controller decides each step; the datapath performs it.
  prbs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .stat(stat)
  );

  prbs_dp #(
    .MAX_BOXES(MAX_BOXES), .MAX_BATCHES(MAX_BATCHES), .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .box_count(box_count),
    .opcode(opcode), .batch_sel(batch_sel), .box_slot(box_slot),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .size_x(size_x), .size_y(size_y), .size_z(size_z), .yaw(yaw),
    .done(done), .hit(hit), .box_index(box_index)
  );
endmodule
`default_nettype wire

### sv/prbs_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Box search controller
// Sequences writes through the CORDIC and queries through the scan.
// ---------------------------------------------------------------------------
module prbs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  output prbs_pkg::cmd_t       cmd,
  input  wire prbs_pkg::status_t stat
);
  import prbs_pkg::*;
  `include "assert_macros.svh"

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_CORDIC;
      end
      ST_CORDIC: begin
        if (stat.is_query) state_next = stat.no_scan ? ST_DONE : ST_SCAN;
        else if (stat.cordic_last) state_next = ST_STORE;
      end
      ST_STORE: state_next = ST_IDLE;
      ST_SCAN: begin
        if (stat.found) state_next = ST_DONE;
        else if (stat.issue_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.found || stat.pipe_empty) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.load = start;
      ST_CORDIC: cmd.cordic = !stat.is_query;
      ST_STORE: cmd.store = 1'b1;
      ST_SCAN: cmd.issue = !stat.found;
      ST_DONE: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `ASSERT_IMP(a_finish_query, clk, rst, cmd.finish, stat.is_query)
  `ASSERT_IMP(a_store_write, clk, rst, cmd.store, !stat.is_query)
endmodule
`default_nettype wire

### sv/prbs_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Box search datapath
// Holds the box tables, the CORDIC unit and the four-stage scan pipeline.
// ---------------------------------------------------------------------------
module prbs_dp #(
  parameter int MAX_BOXES = 256,
  parameter int MAX_BATCHES = 4,
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire prbs_pkg::cmd_t                cmd,
  output prbs_pkg::status_t                  stat,
  input  wire logic [8:0]                    box_count,
  input  wire logic                          opcode,
  input  wire logic [1:0]                    batch_sel,
  input  wire logic [7:0]                    box_slot,
  input  wire logic signed [COORD_WIDTH-1:0] coord_x,
  input  wire logic signed [COORD_WIDTH-1:0] coord_y,
  input  wire logic signed [COORD_WIDTH-1:0] coord_z,
  input  wire logic [COORD_WIDTH-2:0]        size_x,
  input  wire logic [COORD_WIDTH-2:0]        size_y,
  input  wire logic [COORD_WIDTH-2:0]        size_z,
  input  wire logic [15:0]                   yaw,
  output logic                               done,
  output logic                               hit,
  output logic [7:0]                         box_index
);
  import prbs_pkg::*;
  `include "assert_macros.svh"

  localparam int CW = COORD_WIDTH;
  localparam int BW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int GW = (MAX_BATCHES > 1) ? $clog2(MAX_BATCHES) : 1;
  localparam int DEPTH = MAX_BOXES * MAX_BATCHES;
  localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int KW = BW + 1;
  localparam int DW = CW + 1;        // centre offset
  localparam int PW = DW + 19;       // offset times cos or sin
  localparam int LW = PW + 1;        // local coordinate
  localparam int HW = CW - 1;
  localparam int EW = 3 * CW + 3 * HW + 36;

  // Captured item.
  logic is_query;
  logic [GW-1:0] batch;
  logic [BW-1:0] slot;
  logic batch_ok, slot_ok;
  logic signed [CW-1:0] px, py, pz;
  logic [HW-1:0] sx, sy, sz;
  logic [KW-1:0] scan_n;

  // CORDIC state.
  logic signed [19:0] cx, cy;
  logic signed [24:0] cz;
  logic [3:0] step;
  logic flip;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      logic [23:0] a;
      logic [23:0] af;
      logic fl;
      a = {yaw, 8'd0};
      fl = (a[23:22] == 2'd1) || (a[23:22] == 2'd2);
      af = fl ? (a - 24'd8388608) : a;
      is_query <= (opcode == OpQuery);
      batch <= GW'(batch_sel);
      slot <= BW'(box_slot);
      batch_ok <= 32'(batch_sel) < MAX_BATCHES;
      slot_ok <= 32'(box_slot) < MAX_BOXES;
      px <= coord_x; py <= coord_y; pz <= coord_z;
      sx <= size_x; sy <= size_y; sz <= size_z;
      scan_n <= (32'(box_count) > MAX_BOXES) ? KW'(MAX_BOXES) : KW'(box_count);
      flip <= fl;
      cx <= 20'sd39797;
      cy <= '0;
      cz <= 25'(signed'(af));
      step <= '0;
    end else if (cmd.cordic) begin
      logic signed [19:0] xs, ys;
      xs = cx >>> step;
      ys = cy >>> step;
      if (!cz[24]) begin
        cx <= cx - ys; cy <= cy + xs; cz <= cz - 25'(arc_step(step));
      end else begin
        cx <= cx + ys; cy <= cy - xs; cz <= cz + 25'(arc_step(step));
      end
      step <= step + 4'd1;
    end
  end

  function automatic logic signed [17:0] sat18(input logic signed [19:0] v, input logic neg);
    logic signed [20:0] t;
    t = neg ? -21'(v) : 21'(v);
    if (t > 21'sd65536) return 18'sd65536;
    if (t < -21'sd65536) return -18'sd65536;
    return t[17:0];
  endfunction

  // Box table: one wide memory row per entry.
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd;
  logic [KW-1:0] k;
  logic [AW-1:0] wa, ra;

  always_comb begin
    wa = AW'(32'(batch) * MAX_BOXES + 32'(slot));
    ra = AW'(32'(batch) * MAX_BOXES + 32'(k[BW-1:0]));
  end

  always_ff @(posedge clk) begin
    if (cmd.store && batch_ok && slot_ok)
      mem[wa] <= {px, py, pz, sx, sy, sz, sat18(cx, flip), sat18(cy, flip)};
    if (cmd.issue) rd <= mem[ra];
  end

  // Scan pipeline: read, multiply, combine, compare.
  logic [2:0] v;
  logic [BW-1:0] i1, i2;
  logic signed [PW-1:0] m_xc, m_ys, m_yc, m_xs;
  logic [CW:0] dzm;
  logic [HW-1:0] hx2, hy2, hz2, hx3, hy3;
  logic signed [LW-1:0] lx, ly;
  logic zok;
  logic found_r;
  logic [BW-1:0] found_k;

  wire signed [CW-1:0] ex = rd[EW-1 -: CW];
  wire signed [CW-1:0] ey = rd[EW-1-CW -: CW];
  wire signed [CW-1:0] ez = rd[EW-1-2*CW -: CW];
  wire [HW-1:0] ehx = rd[35+3*HW -: HW];
  wire [HW-1:0] ehy = rd[35+2*HW -: HW];
  wire [HW-1:0] ehz = rd[35+HW -: HW];
  wire signed [17:0] ec = rd[35:18];
  wire signed [17:0] es = rd[17:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      v <= '0;
      k <= '0;
      found_r <= 1'b0;
    end else begin
      v[0] <= cmd.issue;
      v[1] <= v[0] && !found_r;
      v[2] <= v[1] && !found_r;
      if (cmd.issue) k <= k + KW'(1);
      if (v[2] && !found_r && (lx < 0 ? -lx : lx) <= LW'({hx3, 15'd0})
          && (ly < 0 ? -ly : ly) <= LW'({hy3, 15'd0}) && zok) begin
        found_r <= 1'b1;
        found_k <= i2;
      end
    end
    i1 <= k[BW-1:0] - BW'(1);
    begin
      logic signed [DW-1:0] dx, dy, dz;
      dx = DW'(px) - DW'(ex);
      dy = DW'(py) - DW'(ey);
      dz = DW'(pz) - DW'(ez);
      m_xc <= dx * ec; m_ys <= dy * es; m_yc <= dy * ec; m_xs <= dx * es;
      dzm <= dz[DW-1] ? (CW+1)'(-dz) : (CW+1)'(dz);
      hx2 <= ehx; hy2 <= ehy; hz2 <= ehz; i2 <= i1;
    end
    lx <= LW'(m_xc) + LW'(m_ys);
    ly <= LW'(m_yc) - LW'(m_xs);
    zok <= {dzm, 1'b0} <= (CW+2)'(hz2);
    hx3 <= hx2; hy3 <= hy2;
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.finish;
    if (cmd.finish) begin
      hit <= found_r;
      box_index <= found_r ? 8'(found_k) : 8'd0;
    end
  end

  always_comb begin
    stat.cordic_last = (step == 4'(CordicSteps - 1));
    stat.issue_last = (k == scan_n - KW'(1));
    stat.found = found_r;
    stat.pipe_empty = (v == 3'd0);
    stat.is_query = is_query;
    stat.no_scan = !batch_ok || (scan_n == '0);
  end

  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `ASSERT_IMP(a_issue_bound, clk, rst, cmd.issue, k < scan_n)
  `ASSERT_IMP(a_hit_index, clk, rst, done && !hit, box_index == 8'd0)
endmodule
`default_nettype wire

### bench/points_in_rotated_box_search_tb.sv
// ---------------------------------------------------------------------------
// Rotated box search testbench
// Loads box tables and queries points against them. Every query answer is
// checked against a predictor (own tables, CORDIC and containment test) or
// a typed row's answer. A short directed table runs first, then random
// traffic under three idling regimes and several box count settings.
// ---------------------------------------------------------------------------
module points_in_rotated_box_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prbs_pkg::*;

  localparam int NumBoxes   = 256;
  localparam int NumBatches = 4;
  localparam int Depth      = NumBoxes * NumBatches;
  localparam int QuarterTurn = 4194304;
  localparam int HalfTurn    = 8388608;
  localparam int Gain        = 39797;
  localparam int Unit        = 65536;
  localparam longint CoordMax = 8388607;
  localparam longint CoordMin = -8388608;
  localparam int SizeMax      = 8388607;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic                cfg_we = 1'b0;
  logic [8:0]          cfg_data = '0;
  logic                opcode = OpWrite;
  logic [1:0]          batch_sel = '0;
  logic [7:0]          box_slot = '0;
  logic signed [23:0]  coord_x = '0;
  logic signed [23:0]  coord_y = '0;
  logic signed [23:0]  coord_z = '0;
  logic [22:0]         size_x = '0;
  logic [22:0]         size_y = '0;
  logic [22:0]         size_z = '0;
  logic [15:0]         yaw = '0;
  logic                done;
  logic                hit;
  logic [7:0]          box_index;

  points_in_rotated_box_search dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .opcode(opcode), .batch_sel(batch_sel), .box_slot(box_slot),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .size_x(size_x), .size_y(size_y), .size_z(size_z), .yaw(yaw),
    .done(done), .hit(hit), .box_index(box_index)
  );

  // A 2 ns clock, high for one nanosecond and low for one.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  typedef struct {
    logic       hit;
    logic [7:0] idx;
  } answer_t;

  // One row of the directed table. Where typed is set, the expected answer
  // is taken from the row itself rather than from the predictor.
  typedef struct {
    logic        op;
    logic [1:0]  batch;
    logic [7:0]  slot;
    logic [23:0] x, y, z;
    logic [22:0] sx, sy, sz;
    logic [15:0] yw;
    bit          typed;
    logic        ehit;
    logic [7:0]  eidx;
  } stim_row_t;

  // The predictor's own copy of the box tables and the box count.
  longint    box_cx [Depth];
  longint    box_cy [Depth];
  longint    box_cz [Depth];
  longint    box_sx [Depth];
  longint    box_sy [Depth];
  longint    box_sz [Depth];
  longint    box_cos[Depth];
  longint    box_sin[Depth];
  int        boxes_in_use = 0;

  // Answers still owed by the block, oldest first.
  answer_t   pending_answers[$];
  int        failures = 0;

  longint    arctan_q24[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                41718, 20860, 10430, 5215, 2608, 1304, 652,
                                326, 163, 81};

  // Cos and sin of the yaw in Q.16, as the block's 16-step CORDIC gives them.
  // The angle is folded into the right half-plane first and the vector is
  // negated afterwards when the fold took place.
  task automatic yaw_to_cos_sin(input logic [15:0] yw, output longint c, output longint s);
    logic [23:0] ang;
    bit          flipped;
    longint      x, y, z, xs, ys;
    ang = {yw, 8'd0};
    flipped = (ang[23:22] == 2'd1) || (ang[23:22] == 2'd2);
    if (flipped) ang = ang - 24'(HalfTurn);
    z = longint'(signed'(ang));
    x = Gain;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - arctan_q24[i];
      end else begin
        x = x + ys; y = y - xs; z = z + arctan_q24[i];
      end
    end
    if (flipped) begin
      x = -x; y = -y;
    end
    c = (x > Unit) ? Unit : (x < -Unit) ? -Unit : x;
    s = (y > Unit) ? Unit : (y < -Unit) ? -Unit : y;
  endtask

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Scans the batch for the lowest box in use that holds the point.
  function automatic answer_t find_box(input logic [1:0] b, input logic [23:0] px,
                                       input logic [23:0] py, input logic [23:0] pz);
    answer_t a;
    int      n, e;
    longint  dx, dy, dz, lx, ly;
    a.hit = 1'b0;
    a.idx = '0;
    n = (boxes_in_use > NumBoxes) ? NumBoxes : boxes_in_use;
    for (int k = 0; k < n; k++) begin
      e  = b * NumBoxes + k;
      dx = longint'(signed'(px)) - box_cx[e];
      dy = longint'(signed'(py)) - box_cy[e];
      dz = longint'(signed'(pz)) - box_cz[e];
      lx = dx * box_cos[e] + dy * box_sin[e];
      ly = dy * box_cos[e] - dx * box_sin[e];
      if (magnitude(lx) <= box_sx[e] * 32768 && magnitude(ly) <= box_sy[e] * 32768 &&
          2 * magnitude(dz) <= box_sz[e]) begin
        a.hit = 1'b1;
        a.idx = 8'(k);
        return a;
      end
    end
    return a;
  endfunction

  // Updates the tables for an accepted write, or returns the answer the
  // block owes for an accepted query.
  task automatic absorb_item(input stim_row_t r);
    int      e;
    answer_t a;
    if (r.op == OpWrite) begin
      e = r.batch * NumBoxes + r.slot;
      box_cx[e] = longint'(signed'(r.x));
      box_cy[e] = longint'(signed'(r.y));
      box_cz[e] = longint'(signed'(r.z));
      box_sx[e] = r.sx;
      box_sy[e] = r.sy;
      box_sz[e] = r.sz;
      yaw_to_cos_sin(r.yw, box_cos[e], box_sin[e]);
    end else begin
      a = find_box(r.batch, r.x, r.y, r.z);
      if (r.typed) begin
        a.hit = r.ehit;
        a.idx = r.eidx;
      end
      pending_answers.push_back(a);
    end
  endtask

  // Puts one item on the ports after a random idle gap and waits for the
  // transfer. On return the clock edge of the transfer has just passed and
  // start is still high, so the caller either sends the next item or calls
  // stop_sending in this same step.
  task automatic send_item(input stim_row_t r, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start     <= 1'b1;
    opcode    <= r.op;
    batch_sel <= r.batch;
    box_slot  <= r.slot;
    coord_x   <= r.x;
    coord_y   <= r.y;
    coord_z   <= r.z;
    size_x    <= r.sx;
    size_y    <= r.sy;
    size_z    <= r.sz;
    yaw       <= r.yw;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_item(r);
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  // Holds the sender off until every owed answer has come and the block has
  // had time to finish any write still in flight.
  task automatic drain();
    stop_sending();
    @(posedge clk);
    while (pending_answers.size() != 0 || busy) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // The register is only written once the block has gone quiet.
  task automatic set_box_count(input int v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= 9'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    boxes_in_use = v & 9'h1FF;
  endtask

  function automatic stim_row_t make_row(input logic op, input logic [1:0] b,
                                         input logic [7:0] sl, input longint x,
                                         input longint y, input longint z,
                                         input int sx, input int sy, input int sz,
                                         input int yw);
    stim_row_t r;
    r.op = op; r.batch = b; r.slot = sl;
    r.x = 24'(x); r.y = 24'(y); r.z = 24'(z);
    r.sx = 23'(sx); r.sy = 23'(sy); r.sz = 23'(sz);
    r.yw = 16'(yw);
    r.typed = 1'b0; r.ehit = 1'b0; r.eidx = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_miss(input stim_row_t r);
    stim_row_t t;
    t = r;
    t.typed = 1'b1;
    t.ehit = 1'b0;
    t.eidx = '0;
    return t;
  endfunction

  // A random box: mostly compact boxes near the origin so that queries land
  // in them, now and then full-range centres and sizes.
  function automatic stim_row_t random_box(input logic [1:0] b, input logic [7:0] sl);
    stim_row_t r;
    longint    span;
    int        smax;
    span = ($urandom_range(9) == 0) ? CoordMax : 4096;
    smax = ($urandom_range(9) == 0) ? SizeMax : 8192;
    r = make_row(OpWrite, b, sl,
                 $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                 $urandom_range(2 * span) - span,
                 $urandom_range(smax), $urandom_range(smax), $urandom_range(smax),
                 $urandom_range(65535));
    return r;
  endfunction

  // A random query. Most points sit close to the centre of a box in use, so
  // that the scan ends on a hit at varying depth; the rest are aimed at any box
  // of the batch, in use or not, or are plain noise.
  function automatic stim_row_t random_query();
    stim_row_t r;
    int        pick, n, k, e;
    longint    ox, oy, oz;
    logic [1:0] b;
    b = 2'($urandom_range(3));
    n = (boxes_in_use > NumBoxes) ? NumBoxes : boxes_in_use;
    pick = $urandom_range(99);
    if (pick < 80) begin
      k = (pick < 65 && n > 0) ? $urandom_range(n - 1) : $urandom_range(NumBoxes - 1);
      e = b * NumBoxes + k;
      ox = longint'($urandom_range(box_sx[e])) - box_sx[e] / 2;
      oy = longint'($urandom_range(box_sy[e])) - box_sy[e] / 2;
      oz = longint'($urandom_range(box_sz[e])) / 2 - box_sz[e] / 4;
      r = make_row(OpQuery, b, 8'($urandom_range(255)),
                   box_cx[e] + ox, box_cy[e] + oy, box_cz[e] + oz, 0, 0, 0, 0);
    end else begin
      r = make_row(OpQuery, b, 8'($urandom_range(255)),
                   longint'($urandom()), longint'($urandom()), longint'($urandom()),
                   $urandom(), $urandom(), $urandom(), $urandom_range(65535));
    end
    return r;
  endfunction

  // Result checker: every strobed answer is matched against the oldest one
  // owed. The receiver cannot stall, so nothing here ever holds off.
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        $error("answer with none owed: hit %0d box_index %0d", hit, box_index);
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          failures++;
        end
        if (box_index !== want.idx) begin
          $error("box_index: expected %0d, got %0d", want.idx, box_index);
          failures++;
        end
      end
    end
  end

  // The slowest correct run stays well under a millisecond of simulated time.
  initial begin
    #5000000;
    $display("[points_in_rotated_box_search] ERROR");
    $finish;
  end

  initial begin
    stim_row_t directed[$];
    stim_row_t r;
    int        idle_pct;
    int        counts[5];

    // The directed table. The two queries straight after reset meet a box
    // count of zero and must miss whatever the tables hold. Then boxes at
    // the extremes of position, size and heading are loaded, and queried
    // with the count at eight.
    directed.push_back(typed_miss(make_row(OpQuery, 2'd0, 8'd255, CoordMax, CoordMax,
                                           CoordMax, SizeMax, SizeMax, SizeMax, 65535)));
    directed.push_back(typed_miss(make_row(OpQuery, 2'd3, 8'd0, CoordMin, CoordMin,
                                           CoordMin, 0, 0, 0, 0)));
    directed.push_back(make_row(OpWrite, 2'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(OpWrite, 2'd0, 8'd1, CoordMax, CoordMin, CoordMax,
                                SizeMax, SizeMax, SizeMax, 65535));
    directed.push_back(make_row(OpWrite, 2'd0, 8'd2, CoordMin, CoordMin, CoordMin,
                                SizeMax, 1, SizeMax, QuarterTurn >> 8));
    directed.push_back(make_row(OpWrite, 2'd0, 8'd3, 0, 0, 0, 1024, 512, 256,
                                HalfTurn >> 8));
    directed.push_back(make_row(OpWrite, 2'd0, 8'd4, 1000, -1000, 0, 2048, 2048, 2048,
                                49152));
    directed.push_back(make_row(OpWrite, 2'd0, 8'd5, 0, 0, 0, 4096, 256, 512, 8192));
    directed.push_back(make_row(OpWrite, 2'd0, 8'd6, -5000, 5000, 0, 512, 4096, 100,
                                24576));
    directed.push_back(make_row(OpWrite, 2'd3, 8'd255, CoordMax, CoordMax, CoordMin,
                                0, SizeMax, 0, 16384));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, 300, 100, 50, 0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, 512, 256, 128, 0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, 1500, -800, 900, 0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, 1400, 100, 0, 0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, -5100, 6000, 50, 0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, CoordMax, CoordMin, CoordMax,
                                0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd0, 8'd0, CoordMin, CoordMin, CoordMin,
                                0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd1, 8'd0, CoordMax, CoordMax, CoordMax,
                                0, 0, 0, 0));
    directed.push_back(make_row(OpQuery, 2'd3, 8'd255, 0, 0, 0, 0, 0, 0, 0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < directed.size(); i++) begin
      if (i == 2) begin
        // Every table entry is loaded before any scan can reach it, so no
        // query ever reads a slot that was never written.
        for (int e = 0; e < Depth; e++)
          send_item(random_box(2'(e / NumBoxes), 8'(e % NumBoxes)), 0);
      end
      if (i == 10) set_box_count(8);
      send_item(directed[i], 0);
    end

    // Random part: three idling regimes, each walking through a run of box
    // counts from one box to more than the table holds.
    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 14 : (p == 1) ? 69 : 0;
      counts = '{1, 255, 256, 300 + 211 * (p == 2), $urandom_range(2, 64)};
      foreach (counts[c]) begin
        set_box_count(counts[c]);
        for (int j = 0; j < 24; j++) begin
          if ($urandom_range(99) < 35)
            r = random_box(2'($urandom_range(3)), 8'($urandom_range(255)));
          else
            r = random_query();
          // Now and then the sender waits for the block to fall quiet.
          if (j == 12) drain();
          send_item(r, idle_pct);
        end
      end
    end
    stop_sending();

    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (failures == 0 && pending_answers.size() == 0) begin
      $display("[points_in_rotated_box_search] OK");
    end else begin
      $display("[points_in_rotated_box_search] ERROR");
    end
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/prbs_pkg.sv
sv/prbs_ctrl.sv
sv/prbs_dp.sv
sv/points_in_rotated_box_search.sv
bench/points_in_rotated_box_search_tb.sv
